[sv/bta_pkg.sv]
// Shared types, constants and arithmetic helpers of the block time averager.
// Used by the top level, the register block, the divider and the core, and by the stream interfaces' users.
`default_nettype none
package bta_pkg;

  localparam int MaxRows   = 1024;
  localparam int RowW      = $clog2(MaxRows);
  localparam int MaxWindow = 16;
  localparam int WinW      = $clog2(MaxWindow);
  localparam int HistDepth = MaxRows * MaxWindow;
  localparam int DivW      = 64;
  localparam int DivCntW   = $clog2(DivW);

  localparam logic [1:0] ModeSingle  = 2'd0;
  localparam logic [1:0] ModeRunning = 2'd1;
  localparam logic [1:0] ModeWindow  = 2'd2;

  localparam logic [2:0] RegRepeatCount  = 3'd0;
  localparam logic [2:0] RegAverageMode  = 3'd1;
  localparam logic [2:0] RegWindowLength = 3'd2;
  localparam logic [2:0] RegRowsInUse    = 3'd3;
  localparam logic [2:0] RegHoldLast     = 3'd4;

  typedef struct packed {
    logic [15:0] repeat_count;
    logic [1:0]  average_mode;
    logic [4:0]  window_length;
    logic [10:0] rows_in_use;
    logic        hold_last;
  } bta_cfg_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [31:0]     divisor;
  } bta_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } bta_div_rsp_t;

  typedef enum logic [2:0] {
    StClear, StIdle, StSum, StBlkDiv, StTotal, StWindow, StNormDiv, StEmit
  } bta_state_e;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    abs64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  // Applies the sign to a quotient magnitude and saturates to 32 bits.
  function automatic logic [31:0] sat32_signed(logic neg, logic [63:0] mag);
    logic [63:0] n;
    n = ~mag + 64'd1;
    if (neg) begin
      sat32_signed = (mag > 64'h8000_0000) ? 32'h8000_0000 : n[31:0];
    end else begin
      sat32_signed = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[sv/bta_if.sv]
// Stream interfaces for sample beats in and result beats out.
// Depends on nothing; payload widths follow the block's field list.
`default_nettype none
interface bta_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface bta_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] average_value;
  logic [9:0]         row_index;
  logic               last_row;
  modport source (output valid, output average_value, output row_index, output last_row,
                  input ready);
  modport sink (input valid, input average_value, input row_index, input last_row,
                output ready);
endinterface
`default_nettype wire

[sv/block_time_averager.sv]
// Top level of the block time averager: APB registers, sequencer, divider.
// Depends on bta_pkg and the stream interfaces in bta_if.sv.
//
//   port        dir   role
//   sample_if   in    one vector element per beat, rows in order
//   result_if   out   averaged element on the final repeat of a block
//   APB (p*)    both  configuration writes and read-back
//
// A beat that is not on the final repeat passes through accept and sum
// write-back. A final-repeat beat makes two passes through the bit-serial
// divider, one for the block average and one for the normalisation; with
// hold_last set it skips both. After reset a pass over every row clears the
// running totals, and no sample is accepted during it. A stalled result holds
// in the output register and blocks only the next final-repeat beat.
`default_nettype none
module block_time_averager
  import bta_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  bta_in_if.sink           sample_if,
  bta_out_if.source        result_if
);

  bta_cfg_t     cfg;
  bta_div_req_t div_req;
  bta_div_rsp_t div_rsp;

  bta_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  bta_divider u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  bta_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg),
    .in_valid_i (sample_if.valid),
    .sample_i   (sample_if.sample_value),
    .in_ready_o (sample_if.ready),
    .out_ready_i(result_if.ready),
    .out_valid_o(result_if.valid),
    .average_o  (result_if.average_value),
    .row_o      (result_if.row_index),
    .last_o     (result_if.last_row),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

endmodule
`default_nettype wire

[sv/bta_cfg_regs.sv]
// APB configuration registers of the block time averager.
// Depends on bta_pkg for the register indexes and the configuration struct.
`default_nettype none
module bta_cfg_regs
  import bta_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output bta_cfg_t         cfg_o
);

  bta_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:2])
        RegRepeatCount:  cfg_d.repeat_count  = pwdata[15:0];
        RegAverageMode:  cfg_d.average_mode  = pwdata[1:0];
        RegWindowLength: cfg_d.window_length = pwdata[4:0];
        RegRowsInUse:    cfg_d.rows_in_use   = pwdata[10:0];
        RegHoldLast:     cfg_d.hold_last     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegRepeatCount:  prdata = {16'b0, cfg_q.repeat_count};
      RegAverageMode:  prdata = {30'b0, cfg_q.average_mode};
      RegWindowLength: prdata = {27'b0, cfg_q.window_length};
      RegRowsInUse:    prdata = {21'b0, cfg_q.rows_in_use};
      RegHoldLast:     prdata = {31'b0, cfg_q.hold_last};
      default:         prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_count  <= 16'd1;
      cfg_q.average_mode  <= ModeSingle;
      cfg_q.window_length <= 5'd1;
      cfg_q.rows_in_use   <= 11'd1024;
      cfg_q.hold_last     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

[sv/bta_divider.sv]
// Restoring radix-2 divider: 64-bit unsigned dividend by 32-bit divisor.
// One quotient bit per cycle; depends on bta_pkg for the request types.
`default_nettype none
module bta_divider
  import bta_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  bta_div_req_t req_i,
  output bta_div_rsp_t rsp_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [31:0]        rem_q, dvs_q;
  logic [DivW-1:0]    quo_q;
  logic [32:0]        shifted, diff;
  logic               fits;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(DivW - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[sv/bta_core.sv]
// Sequencer and row memories: block sums, running totals and window history.
// Depends on bta_pkg; drives the shared divider through its request struct.
`default_nettype none
module bta_core
  import bta_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  bta_cfg_t                cfg_i,
  input  wire logic               in_valid_i,
  input  wire logic signed [31:0] sample_i,
  output logic                    in_ready_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [31:0]      average_o,
  output logic [RowW-1:0]         row_o,
  output logic                    last_o,
  output bta_div_req_t            div_req_o,
  input  bta_div_rsp_t            div_rsp_i
);

  bta_state_e state_q, state_d;

  logic [RowW:0]             clr_q;
  logic [RowW-1:0]           row_q, row_d;
  logic [15:0]               rep_q, rep_d;
  logic [31:0]               norm_q, norm_d;
  logic [WinW-1:0]           widx_q, widx_d;
  logic                      wfull_q, wfull_d;
  logic signed [31:0]        sample_q;
  logic signed [31:0]        avg_q, avg_d;
  logic signed [31:0]        res_q, res_d;
  logic signed [63:0]        tot_q, tot_d;
  logic [31:0]               nnorm_q, nnorm_d;
  logic [WinW:0]             nidx_q, nidx_d;
  logic                      nfull_q, nfull_d;
  logic                      neg_q, neg_d;
  logic                      last_q, last_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [31:0]        out_avg_q;
  logic [RowW-1:0]           out_row_q;
  logic                      out_last_q;

  logic signed [47:0] bsum_mem [MaxRows];
  logic signed [63:0] tot_mem  [MaxRows];
  logic signed [31:0] hist_mem [HistDepth];
  logic signed [47:0] bsum_rd_q;
  logic signed [63:0] tot_rd_q;
  logic signed [31:0] hist_rd_q;

  logic                      accept, emit;
  logic                      bs_we, tot_we, hist_we;
  logic signed [47:0]        bs_new;
  logic signed [63:0]        tot_wdata, t_win, prod;
  logic [RowW-1:0]           tot_waddr;
  logic [15:0]               reps;
  logic [10:0]               rows;
  logic [4:0]                wl;
  logic                      last_now, final_now;
  logic                      is_win, is_run;

  // Clamp the configuration the same way every beat sees it.
  always_comb begin
    reps = (cfg_i.repeat_count == 16'd0) ? 16'd1 : cfg_i.repeat_count;
    if (cfg_i.rows_in_use == 11'd0) rows = 11'd1;
    else if (cfg_i.rows_in_use > 11'(MaxRows)) rows = 11'(MaxRows);
    else rows = cfg_i.rows_in_use;
    if (cfg_i.window_length == 5'd0) wl = 5'd1;
    else if (cfg_i.window_length > 5'(MaxWindow)) wl = 5'(MaxWindow);
    else wl = cfg_i.window_length;
    is_win = cfg_i.average_mode == ModeWindow;
    is_run = cfg_i.average_mode == ModeRunning;
  end

  assign in_ready_o  = state_q == StIdle;
  assign accept      = in_valid_i & in_ready_o;
  assign emit        = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign row_o       = out_row_q;
  assign last_o      = out_last_q;

  assign bs_new    = cfg_i.hold_last ? 48'(sample_q)
                   : ((rep_q == 16'd0) ? 48'sd0 : bsum_rd_q) + 48'(sample_q);
  assign last_now  = ({1'b0, row_q} + 11'd1) >= rows;
  assign final_now = ({1'b0, rep_q} + 17'd1) >= {1'b0, reps};
  assign t_win     = (is_win && wfull_q) ? sat_add64(tot_q, -64'(hist_rd_q)) : tot_q;
  assign prod      = 64'($signed(avg_q) * $signed({1'b0, nnorm_q}));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:   if (clr_q == (RowW + 1)'(MaxRows - 1)) state_d = StIdle;
      StIdle:    if (accept) state_d = StSum;
      StSum: begin
        if (!final_now) state_d = StIdle;
        else if (cfg_i.hold_last) state_d = StTotal;
        else state_d = StBlkDiv;
      end
      StBlkDiv:  if (div_rsp_i.done) state_d = StTotal;
      StTotal:   state_d = StWindow;
      StWindow:  state_d = cfg_i.hold_last ? StEmit : StNormDiv;
      StNormDiv: if (div_rsp_i.done) state_d = StEmit;
      StEmit:    if (emit) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    row_d = row_q; rep_d = rep_q; norm_d = norm_q; widx_d = widx_q; wfull_d = wfull_q;
    avg_d = avg_q; res_d = res_q; tot_d = tot_q; nnorm_d = nnorm_q;
    nidx_d = nidx_q; nfull_d = nfull_q; neg_d = neg_q; last_d = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    bs_we = 1'b0; hist_we = 1'b0; tot_we = 1'b0;
    tot_waddr = row_q; tot_wdata = t_win;
    div_req_o = '0;
    case (state_q)
      StClear: begin
        tot_we    = 1'b1;
        tot_waddr = clr_q[RowW-1:0];
        tot_wdata = 64'sd0;
      end
      StSum: begin
        bs_we  = 1'b1;
        last_d = last_now;
        neg_d  = bs_new[47];
        avg_d  = sample_q;
        if (!final_now) begin
          row_d = last_now ? '0 : row_q + 1'b1;
          if (last_now) rep_d = rep_q + 16'd1;
        end else if (!cfg_i.hold_last) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = abs64(64'(bs_new));
          div_req_o.divisor  = {16'b0, reps};
        end
      end
      StBlkDiv: begin
        if (div_rsp_i.done) avg_d = sat32_signed(neg_q, div_rsp_i.quotient);
      end
      StTotal: begin
        nidx_d  = {1'b0, widx_q} + 1'b1;
        nfull_d = wfull_q;
        if (nidx_d >= wl) begin
          nidx_d  = '0;
          nfull_d = 1'b1;
        end
        if (is_win) begin
          hist_we = 1'b1;
          tot_d   = sat_add64(tot_rd_q, 64'(avg_q));
          nnorm_d = nfull_d ? 32'(wl) : 32'(nidx_d);
        end else if (is_run) begin
          tot_d   = sat_add64(tot_rd_q, 64'(avg_q));
          nnorm_d = (norm_q == 32'hFFFF_FFFF) ? norm_q : norm_q + 32'd1;
        end else begin
          tot_d   = 64'(avg_q);
          nnorm_d = 32'd1;
        end
      end
      StWindow: begin
        tot_we    = 1'b1;
        tot_wdata = cfg_i.hold_last ? prod : t_win;
        res_d     = avg_q;
        neg_d     = t_win[63];
        if (!cfg_i.hold_last) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = abs64(t_win);
          div_req_o.divisor  = nnorm_q;
        end
      end
      StNormDiv: begin
        if (div_rsp_i.done) res_d = sat32_signed(neg_q, div_rsp_i.quotient);
      end
      StEmit: begin
        if (emit) begin
          out_valid_d = 1'b1;
          if (last_q) begin
            row_d  = '0;
            rep_d  = '0;
            norm_d = nnorm_q;
            if (is_win) begin
              widx_d  = nidx_q[WinW-1:0];
              wfull_d = nfull_q;
            end
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      row_q       <= '0;
      rep_q       <= '0;
      norm_q      <= '0;
      widx_q      <= '0;
      wfull_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      row_q       <= row_d;
      rep_q       <= rep_d;
      norm_q      <= norm_d;
      widx_q      <= widx_d;
      wfull_q     <= wfull_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) sample_q <= sample_i;
    avg_q   <= avg_d;
    res_q   <= res_d;
    tot_q   <= tot_d;
    nnorm_q <= nnorm_d;
    nidx_q  <= nidx_d;
    nfull_q <= nfull_d;
    neg_q   <= neg_d;
    last_q  <= last_d;
    if (emit) begin
      out_avg_q  <= res_q;
      out_row_q  <= row_q;
      out_last_q <= last_q;
    end
  end

  // All three memories are read at the accept edge, and any write-back comes
  // later in the same beat; beats never overlap, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (bs_we) bsum_mem[row_q] <= bs_new;
    if (accept) bsum_rd_q <= bsum_mem[row_q];
  end

  always_ff @(posedge clk_i) begin
    if (tot_we) tot_mem[tot_waddr] <= tot_wdata;
    if (accept) tot_rd_q <= tot_mem[row_q];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[{widx_q, row_q}] <= avg_q;
    if (accept) hist_rd_q <= hist_mem[{widx_q, row_q}];
  end

endmodule
`default_nettype wire

[sv/bta_checker.sv]
// Port-level checks for the block time averager, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module bta_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_avg_i,
  input wire logic [9:0]  out_row_i,
  input wire logic        out_last_i,
  input wire logic [31:0] prdata_i
);

  // A waiting result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_avg_i)
      && $stable(out_row_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // Beats are processed one at a time, so ready drops after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample accepted in back-to-back cycles");

  // No register is wider than 16 bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata_i[31:16] == 16'b0)
    else $error("read data has bits above the widest register");

endmodule

bind block_time_averager bta_checker u_bta_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (sample_if.valid),
  .in_ready_i (sample_if.ready),
  .out_valid_i(result_if.valid),
  .out_ready_i(result_if.ready),
  .out_avg_i  (result_if.average_value),
  .out_row_i  (result_if.row_index),
  .out_last_i (result_if.last_row),
  .prdata_i   (prdata)
);
`default_nettype wire

[tb/sv/bta_scoreboard.sv]
`timescale 1ns / 100ps
// Scoreboard for the block time averager: tracks register writes, predicts
// the averaged rows from accepted sample beats and checks each result beat.
// Depends on bta_pkg and the stream interfaces in bta_if.sv.
module bta_scoreboard
  import bta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  bta_in_if           sample_if,
  bta_out_if          result_if,
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] average_value;
    logic [9:0]  row_index;
    logic        last_row;
  } row_average_t;

  row_average_t expected_rows[$];
  int           errors;

  logic [15:0] cfg_repeat;
  logic [1:0]  cfg_mode;
  logic [4:0]  cfg_window;
  logic [10:0] cfg_rows;
  logic        cfg_hold;

  logic [9:0]  row_cnt;
  logic [15:0] rep_cnt;
  longint      blk_acc[MaxRows];
  longint      tot_acc[MaxRows];
  int          ring[HistDepth];
  logic [3:0]  ring_pos;
  logic        ring_full;
  int unsigned blocks_seen;

  function automatic longint clamp_add64(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  task automatic fold_sample(input logic signed [31:0] raw);
    int unsigned  reps;
    int unsigned  rows;
    int unsigned  wl;
    int unsigned  row;
    int unsigned  slot;
    int unsigned  nxt_pos;
    int unsigned  count;
    logic [1:0]   mode;
    bit           last;
    bit           final_rep;
    bit           nxt_full;
    longint       avg;
    longint       t;
    logic [63:0]  mag;
    logic [63:0]  quot;
    row_average_t res;
    reps = (cfg_repeat == 0) ? 1 : cfg_repeat;
    rows = (cfg_rows == 0) ? 1 : ((cfg_rows > MaxRows) ? MaxRows : cfg_rows);
    wl = (cfg_window == 0) ? 1 : ((cfg_window > MaxWindow) ? MaxWindow : cfg_window);
    mode = (cfg_mode == 2'd3) ? ModeSingle : cfg_mode;
    row = row_cnt;

    if (rep_cnt == 0) blk_acc[row] = 0;
    if (cfg_hold) begin
      blk_acc[row] = raw;
    end else begin
      blk_acc[row] = blk_acc[row] + raw;
    end
    last = (row + 1 >= rows);
    final_rep = (rep_cnt + 1 >= reps);

    if (!final_rep) begin
      if (last) begin
        row_cnt = 0;
        rep_cnt = rep_cnt + 16'd1;
      end else begin
        row_cnt = 10'(row + 1);
      end
      return;
    end

    if (cfg_hold) begin
      avg = blk_acc[row];
    end else begin
      avg = blk_acc[row] / longint'(reps);
      if (avg > 64'sh7FFF_FFFF) avg = 64'sh7FFF_FFFF;
      if (avg < -64'sh8000_0000) avg = -64'sh8000_0000;
    end

    nxt_pos = ring_pos;
    nxt_full = ring_full;
    if (mode == ModeSingle) begin
      tot_acc[row] = avg;
      count = 1;
    end else if (mode == ModeRunning) begin
      tot_acc[row] = clamp_add64(tot_acc[row], avg);
      count = (blocks_seen == 32'hFFFF_FFFF) ? blocks_seen : blocks_seen + 1;
    end else begin
      // The ring keeps one slot per row for each of the last blocks.
      slot = ring_pos * MaxRows + row;
      tot_acc[row] = clamp_add64(tot_acc[row], avg);
      if (ring_full) tot_acc[row] = clamp_add64(tot_acc[row], -longint'(ring[slot]));
      ring[slot] = int'(avg);
      nxt_pos = ring_pos + 1;
      if (nxt_pos >= wl) begin
        nxt_pos = 0;
        nxt_full = 1'b1;
      end
      count = nxt_full ? wl : nxt_pos;
    end
    if (cfg_hold) tot_acc[row] = avg * longint'(count);

    t = tot_acc[row];
    mag = (t < 0) ? 64'(-t) : 64'(t);
    quot = mag / 64'(count);
    if (t < 0) begin
      res.average_value = (quot > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quot);
    end else begin
      res.average_value = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
    end
    res.row_index = row[9:0];
    res.last_row = last;
    expected_rows.push_back(res);

    if (last) begin
      row_cnt = 0;
      rep_cnt = 0;
      blocks_seen = count;
      if (mode == ModeWindow) begin
        ring_pos = nxt_pos[3:0];
        ring_full = nxt_full;
      end
    end else begin
      row_cnt = 10'(row + 1);
    end
  endtask

  task automatic check_result();
    row_average_t want;
    if (expected_rows.size() == 0) begin
      $display("%0t: result beat with nothing expected: value %h row %0d last %0b",
               $time, result_if.average_value, result_if.row_index, result_if.last_row);
      errors++;
      return;
    end
    want = expected_rows.pop_front();
    if (result_if.average_value !== want.average_value) begin
      $display("%0t: average_value expected %h actual %h", $time,
               want.average_value, result_if.average_value);
      errors++;
    end
    if (result_if.row_index !== want.row_index) begin
      $display("%0t: row_index expected %0d actual %0d", $time,
               want.row_index, result_if.row_index);
      errors++;
    end
    if (result_if.last_row !== want.last_row) begin
      $display("%0t: last_row expected %0b actual %0b", $time,
               want.last_row, result_if.last_row);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_repeat = 16'd1;
      cfg_mode = ModeSingle;
      cfg_window = 5'd1;
      cfg_rows = 11'd1024;
      cfg_hold = 1'b0;
      row_cnt = '0;
      rep_cnt = '0;
      ring_pos = '0;
      ring_full = 1'b0;
      blocks_seen = 0;
      for (int i = 0; i < MaxRows; i++) begin
        blk_acc[i] = 0;
        tot_acc[i] = 0;
      end
      for (int i = 0; i < HistDepth; i++) ring[i] = 0;
      expected_rows.delete();
      errors = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      // Results leave before new samples enter, so check first.
      if (result_if.valid && result_if.ready) check_result();
      if (sample_if.valid && sample_if.ready) fold_sample(sample_if.sample_value);
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegRepeatCount:  cfg_repeat = pwdata[15:0];
          RegAverageMode:  cfg_mode = pwdata[1:0];
          RegWindowLength: cfg_window = pwdata[4:0];
          RegRowsInUse:    cfg_rows = pwdata[10:0];
          RegHoldLast:     cfg_hold = pwdata[0];
          default: ;
        endcase
      end
      mismatches_o <= errors;
      pending_o <= expected_rows.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the block time averager testbench: clock, reset, register writes,
// sample and result stream drivers with random idling, and the verdict.
// Depends on bta_pkg, bta_if.sv, the block itself and bta_scoreboard.
module tb_top;
  import bta_pkg::*;

  localparam int CycleLimit = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;
  int          cycles;
  int          sent_items;
  int          stall_left;
  bit          sender_idles;
  bit          receiver_stalls;
  int unsigned cur_rows;
  int unsigned cur_reps;

  bta_in_if  samples();
  bta_out_if results();

  block_time_averager i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample_if(samples),
    .result_if(results)
  );

  bta_scoreboard i_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .sample_if   (samples),
    .result_if   (results),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts while enabled.
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (receiver_stalls && stall_left == 0 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        results.ready <= 1'b0;
        stall_left--;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits for the last result, then lets a trailing non-final beat drain.
  // The first edge lets the count of a just accepted beat show up.
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] reps, input logic [1:0] mode,
                                input logic [4:0] wl, input logic [10:0] rows,
                                input logic hold);
    settle();
    write_reg(RegRepeatCount, 32'(reps));
    write_reg(RegAverageMode, 32'(mode));
    write_reg(RegWindowLength, 32'(wl));
    write_reg(RegRowsInUse, 32'(rows));
    write_reg(RegHoldLast, 32'(hold));
    cur_reps = (reps == 0) ? 1 : reps;
    cur_rows = (rows == 0) ? 1 : ((rows > MaxRows) ? MaxRows : rows);
  endtask

  task automatic send_beat(input logic [31:0] v);
    int gap;
    gap = (sender_idles && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample_value <= v;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    sent_items++;
  endtask

  function automatic logic [31:0] pick_sample();
    logic s;
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return {{14{s}}, 18'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic stream_vectors(input int nvec);
    repeat (nvec * cur_rows * cur_reps) send_beat(pick_sample());
    samples.valid <= 1'b0;
  endtask

  task automatic random_phase();
    logic [1:0]  mode;
    logic [15:0] reps;
    logic [10:0] rows;
    mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: reps = 16'd0;
      1: reps = 16'($urandom_range(5, 9));
      default: reps = 16'($urandom_range(1, 4));
    endcase
    // Window mode stays within the rows whose ring slots were all filled.
    if (mode == ModeWindow) begin
      rows = 11'($urandom_range(0, 8));
    end else begin
      rows = 11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12));
    end
    apply_settings(reps, mode, 5'($urandom_range(0, 31)), rows, $urandom_range(0, 3) == 0);
    stream_vectors($urandom_range(1, 6));
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples.valid = 1'b0;
    samples.sample_value = '0;
    results.ready = 1'b0;
    cycles = 0;
    sent_items = 0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, one block per vector.
    apply_settings(16'd1, ModeSingle, 5'd1, 11'd4, 1'b0);
    send_beat(32'h7FFF_FFFF);
    send_beat(32'h8000_0000);
    send_beat(32'h0000_0000);
    send_beat(32'hFFFF_FFFF);
    samples.valid <= 1'b0;
    // Block sums beyond 32 bits, running mode.
    apply_settings(16'd2, ModeRunning, 5'd1, 11'd2, 1'b0);
    repeat (2) begin
      send_beat(32'h7FFF_FFFF);
      send_beat(32'h8000_0000);
    end
    samples.valid <= 1'b0;
    // Hold last with the unused mode code.
    apply_settings(16'd3, 2'd3, 5'd1, 11'd2, 1'b1);
    stream_vectors(1);
    // Zero repeat count and zero rows act as one.
    apply_settings(16'd0, ModeRunning, 5'd0, 11'd0, 1'b0);
    stream_vectors(3);
    // Row range and repeat count lowered in the middle of a block.
    apply_settings(16'd3, ModeSingle, 5'd1, 11'd6, 1'b0);
    repeat (9) send_beat(pick_sample());
    samples.valid <= 1'b0;
    settle();
    write_reg(RegRowsInUse, 32'd2);
    write_reg(RegRepeatCount, 32'd2);
    send_beat(pick_sample());
    samples.valid <= 1'b0;

    // First use of the window fills every slot for rows 0 to 7.
    apply_settings(16'd1, ModeWindow, 5'd31, 11'd8, 1'b0);
    stream_vectors(16);

    // Long phases, cheap per beat or one vector only.
    apply_settings(16'd1, ModeRunning, 5'd16, 11'd2047, 1'b0);
    stream_vectors(1);
    apply_settings(16'd4, ModeSingle, 5'd1, 11'd3, 1'b1);
    stream_vectors(1);
    sender_idles = 1'b0;
    apply_settings(16'd60, ModeRunning, 5'd1, 11'd1, 1'b0);
    stream_vectors(1);
    sender_idles = 1'b1;

    while (sent_items < 1300) random_phase();

    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    repeat (4) random_phase();

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
